// File: hdl/dnsx_pkg.sv
package dnsx_pkg;

  // One frame byte as it arrives from the receive path.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_beat_t;

  // One parse result, given on the last byte of a frame.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ip_address;
  } out_beat_t;

  // Result of one byte step, handed from the parser to the result register.
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_t;

  // Result status codes.
  localparam logic [2:0] ST_IGNORED    = 3'd0;
  localparam logic [2:0] ST_NO_ANSWERS = 3'd1;
  localparam logic [2:0] ST_RESOLVED   = 3'd2;
  localparam logic [2:0] ST_NO_A       = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_TRANSACTION_ID = 1'b0;
  localparam logic CFG_SERVER_PORT    = 1'b1;

  // Configuration reset values.
  localparam logic [15:0] TRANSACTION_ID_RESET = 16'h55AA;
  localparam logic [15:0] SERVER_PORT_RESET    = 16'd53;

  // Header field values that a reply must carry.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;

  // Byte offsets within the frame at which the header checks happen.
  localparam int DNS_BASE       = 42;
  localparam int OFF_ETHERTYPE  = 13;
  localparam int OFF_IP_PROTO   = 23;
  localparam int OFF_SRC_PORT   = 35;
  localparam int OFF_DNS_ID     = DNS_BASE + 1;
  localparam int OFF_AN_COUNT   = DNS_BASE + 7;
  localparam int OFF_HEADER_END = 53;

  // Name parsing and record layout.
  localparam logic [7:0]  PTR_MARK    = 8'hC0;
  localparam logic [15:0] QTAIL_LEN   = 16'd4;
  localparam logic [15:0] AHDR_LEN    = 16'd10;
  localparam logic [15:0] RR_TYPE_A   = 16'd1;
  localparam logic [15:0] A_RDLENGTH  = 16'd4;

endpackage

// File: hdl/dnsx_parser.sv
module dnsx_parser #(
  parameter int MAX_FRAME_BYTES = 2048,
  localparam int OW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat_accept,
  input  dnsx_pkg::in_beat_t in_beat,
  input  logic [15:0]      transaction_id,
  input  logic [15:0]      server_port,
  output dnsx_pkg::res_t   res
);

  typedef enum logic [11:0] {
    PH_HEADER     = 12'b0000_0000_0001,
    PH_QNAME_LEN  = 12'b0000_0000_0010,
    PH_QNAME_SKIP = 12'b0000_0000_0100,
    PH_QNAME_PTR  = 12'b0000_0000_1000,
    PH_QTAIL      = 12'b0000_0001_0000,
    PH_ANAME_LEN  = 12'b0000_0010_0000,
    PH_ANAME_SKIP = 12'b0000_0100_0000,
    PH_ANAME_PTR  = 12'b0000_1000_0000,
    PH_AHDR       = 12'b0001_0000_0000,
    PH_RDATA      = 12'b0010_0000_0000,
    PH_ADDR       = 12'b0100_0000_0000,
    PH_DONE       = 12'b1000_0000_0000
  } phase_t;

  logic [OW-1:0] offset_r,  offset_nxt;
  phase_t        phase_r,   phase_nxt;
  logic [15:0]   skip_r,    skip_nxt;
  logic [15:0]   ans_r,     ans_nxt;
  logic [15:0]   rtype_r,   rtype_nxt;
  logic [15:0]   rlen_r,    rlen_nxt;
  logic [31:0]   addr_r,    addr_nxt;
  logic [2:0]    verdict_r, verdict_nxt;

  // Values after this byte has been parsed, before the end-of-frame clear.
  phase_t      p_phase;
  logic [15:0] p_skip;
  logic [15:0] p_ans;
  logic [15:0] p_rtype;
  logic [15:0] p_rlen;
  logic [31:0] p_addr;
  logic [2:0]  p_verdict;

  logic [7:0]  b;
  logic [15:0] word;
  logic [15:0] skip_dec;
  logic [15:0] ans_dec;
  logic        in_window;
  logic [2:0]  status;

  assign b         = in_beat.frame_byte;
  assign word      = {rtype_r[7:0], b};
  assign skip_dec  = skip_r - 16'd1;
  assign ans_dec   = ans_r - 16'd1;
  assign in_window = (offset_r < OW'(MAX_FRAME_BYTES));

  // Byte parser: one state step per frame byte.
  always_comb begin
    p_phase   = phase_r;
    p_skip    = skip_r;
    p_ans     = ans_r;
    p_rtype   = rtype_r;
    p_rlen    = rlen_r;
    p_addr    = addr_r;
    p_verdict = verdict_r;
    case (phase_r)
      PH_HEADER: begin
        p_rtype = word;
        if (offset_r == OW'(dnsx_pkg::OFF_ETHERTYPE) && word != dnsx_pkg::ETHERTYPE_IPV4) begin
          p_verdict = dnsx_pkg::ST_IGNORED;
          p_phase   = PH_DONE;
        end else if (offset_r == OW'(dnsx_pkg::OFF_IP_PROTO) && b != dnsx_pkg::IP_PROTO_UDP) begin
          p_verdict = dnsx_pkg::ST_IGNORED;
          p_phase   = PH_DONE;
        end else if (offset_r == OW'(dnsx_pkg::OFF_SRC_PORT) && word != server_port) begin
          p_verdict = dnsx_pkg::ST_IGNORED;
          p_phase   = PH_DONE;
        end else if (offset_r == OW'(dnsx_pkg::OFF_DNS_ID) && word != transaction_id) begin
          p_verdict = dnsx_pkg::ST_IGNORED;
          p_phase   = PH_DONE;
        end else if (offset_r == OW'(dnsx_pkg::OFF_AN_COUNT)) begin
          p_ans = word;
          if (word == 16'd0) begin
            p_verdict = dnsx_pkg::ST_NO_ANSWERS;
            p_phase   = PH_DONE;
          end
        end else if (offset_r == OW'(dnsx_pkg::OFF_HEADER_END)) begin
          p_phase = PH_QNAME_LEN;
        end
      end
      PH_QNAME_LEN: begin
        if (b == 8'd0) begin
          p_skip  = dnsx_pkg::QTAIL_LEN;
          p_phase = PH_QTAIL;
        end else if ((b & dnsx_pkg::PTR_MARK) == dnsx_pkg::PTR_MARK) begin
          p_phase = PH_QNAME_PTR;
        end else begin
          p_skip  = {8'd0, b};
          p_phase = PH_QNAME_SKIP;
        end
      end
      PH_ANAME_LEN: begin
        if (b == 8'd0) begin
          p_skip  = dnsx_pkg::AHDR_LEN;
          p_rtype = 16'd0;
          p_rlen  = 16'd0;
          p_phase = PH_AHDR;
        end else if ((b & dnsx_pkg::PTR_MARK) == dnsx_pkg::PTR_MARK) begin
          p_phase = PH_ANAME_PTR;
        end else begin
          p_skip  = {8'd0, b};
          p_phase = PH_ANAME_SKIP;
        end
      end
      PH_QNAME_SKIP: begin
        p_skip = skip_dec;
        if (skip_dec == 16'd0) begin
          p_phase = PH_QNAME_LEN;
        end
      end
      PH_ANAME_SKIP: begin
        p_skip = skip_dec;
        if (skip_dec == 16'd0) begin
          p_phase = PH_ANAME_LEN;
        end
      end
      PH_QNAME_PTR: begin
        p_skip  = dnsx_pkg::QTAIL_LEN;
        p_phase = PH_QTAIL;
      end
      PH_ANAME_PTR: begin
        p_skip  = dnsx_pkg::AHDR_LEN;
        p_rtype = 16'd0;
        p_rlen  = 16'd0;
        p_phase = PH_AHDR;
      end
      PH_QTAIL: begin
        p_skip = skip_dec;
        if (skip_dec == 16'd0) begin
          p_phase = PH_ANAME_LEN;
        end
      end
      PH_AHDR: begin
        // The first two bytes are the type, the last two the data length.
        if (skip_r >= 16'd9) begin
          p_rtype = {rtype_r[7:0], b};
        end else if (skip_r <= 16'd2) begin
          p_rlen = {rlen_r[7:0], b};
        end
        p_skip = skip_dec;
        if (skip_dec == 16'd0) begin
          if (p_rtype == dnsx_pkg::RR_TYPE_A && p_rlen == dnsx_pkg::A_RDLENGTH) begin
            p_skip  = dnsx_pkg::A_RDLENGTH;
            p_addr  = 32'd0;
            p_phase = PH_ADDR;
          end else if (p_rlen == 16'd0) begin
            p_ans = ans_dec;
            if (ans_dec == 16'd0) begin
              p_verdict = dnsx_pkg::ST_NO_A;
              p_phase   = PH_DONE;
            end else begin
              p_phase = PH_ANAME_LEN;
            end
          end else begin
            p_skip  = p_rlen;
            p_phase = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        p_skip = skip_dec;
        if (skip_dec == 16'd0) begin
          p_ans = ans_dec;
          if (ans_dec == 16'd0) begin
            p_verdict = dnsx_pkg::ST_NO_A;
            p_phase   = PH_DONE;
          end else begin
            p_phase = PH_ANAME_LEN;
          end
        end
      end
      PH_ADDR: begin
        p_addr = {addr_r[23:0], b};
        p_skip = skip_dec;
        if (skip_dec == 16'd0) begin
          p_verdict = dnsx_pkg::ST_RESOLVED;
          p_phase   = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Commit the step on an accepted beat; the last byte also reports and clears.
  always_comb begin
    offset_nxt  = offset_r;
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    ans_nxt     = ans_r;
    rtype_nxt   = rtype_r;
    rlen_nxt    = rlen_r;
    addr_nxt    = addr_r;
    verdict_nxt = verdict_r;
    if (beat_accept && in_window) begin
      offset_nxt  = offset_r + OW'(1);
      phase_nxt   = p_phase;
      skip_nxt    = p_skip;
      ans_nxt     = p_ans;
      rtype_nxt   = p_rtype;
      rlen_nxt    = p_rlen;
      addr_nxt    = p_addr;
      verdict_nxt = p_verdict;
    end

    status = (phase_nxt == PH_DONE) ? verdict_nxt : dnsx_pkg::ST_TRUNCATED;
    res.valid           = beat_accept && in_beat.last_byte;
    res.beat.status     = status;
    res.beat.ip_address = (status == dnsx_pkg::ST_RESOLVED) ? addr_nxt : 32'd0;

    if (beat_accept && in_beat.last_byte) begin
      offset_nxt  = '0;
      phase_nxt   = PH_HEADER;
      skip_nxt    = 16'd0;
      ans_nxt     = 16'd0;
      rtype_nxt   = 16'd0;
      rlen_nxt    = 16'd0;
      addr_nxt    = 32'd0;
      verdict_nxt = dnsx_pkg::ST_IGNORED;
    end
  end

  // Per-frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      phase_r   <= PH_HEADER;
      skip_r    <= 16'd0;
      ans_r     <= 16'd0;
      rtype_r   <= 16'd0;
      rlen_r    <= 16'd0;
      addr_r    <= 32'd0;
      verdict_r <= dnsx_pkg::ST_IGNORED;
    end else begin
      offset_r  <= offset_nxt;
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      ans_r     <= ans_nxt;
      rtype_r   <= rtype_nxt;
      rlen_r    <= rlen_nxt;
      addr_r    <= addr_nxt;
      verdict_r <= verdict_nxt;
    end
  end

endmodule

// File: hdl/dnsx_out_reg.sv
module dnsx_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  dnsx_pkg::res_t      res,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output dnsx_pkg::out_beat_t out_data
);

  logic                valid_r, valid_nxt;
  dnsx_pkg::out_beat_t data_r,  data_nxt;

  // Load a new result, or drop the held one once it has been taken.
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
      data_nxt  = res.beat;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // The register cannot take a new result while its beat is held back.
  assign full      = valid_r && out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/dns_reply_a_record_extractor_top.sv
// DNS reply A-record extractor. Frame bytes enter one per cycle on the in_ channel, with
// last_byte set on the final byte; the block checks for IPv4/UDP from the configured
// server port with the expected DNS id, walks the question and answer sections and
// returns one beat per frame (status and IPv4 address) in the cycle after the last byte.
// Each byte is a single state step, so the block takes one byte every cycle. The only
// stall is on a last byte while the previous result still sits in the result register
// and the receiver stalls it; other bytes keep flowing. Bytes at offsets of
// MAX_FRAME_BYTES and beyond are counted out and not parsed. Configuration writes take
// effect at the next edge and should be made between frames.
module dns_reply_a_record_extractor_top #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dnsx_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dnsx_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);

  logic [15:0]    transaction_id_r;
  logic [15:0]    server_port_r;
  logic           out_full;
  logic           beat_accept;
  dnsx_pkg::res_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transaction_id_r <= dnsx_pkg::TRANSACTION_ID_RESET;
      server_port_r    <= dnsx_pkg::SERVER_PORT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dnsx_pkg::CFG_TRANSACTION_ID: transaction_id_r <= cfg_wdata;
        dnsx_pkg::CFG_SERVER_PORT:    server_port_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Only a last byte needs room in the result register.
  assign in_stall    = out_full && in_data.last_byte;
  assign beat_accept = in_valid && !in_stall;

  dnsx_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat_accept   (beat_accept),
    .in_beat       (in_data),
    .transaction_id(transaction_id_r),
    .server_port   (server_port_r),
    .res           (res)
  );

  dnsx_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .full     (out_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// File: hdl/dnsx_checker.sv
module dnsx_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input dnsx_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input dnsx_pkg::out_beat_t out_data
);

  // A held result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A held result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Every accepted last byte yields a result beat in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_byte |=> out_valid)
    else $error("no result after the last byte of a frame");

  // The address is zero on every status but resolved.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != dnsx_pkg::ST_RESOLVED |-> out_data.ip_address == 32'd0)
    else $error("address given on an unresolved frame");

  // A byte that is not last is never stalled.
  a_no_mid_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_data.last_byte |-> !in_stall)
    else $error("stall on a byte inside a frame");

endmodule

bind dns_reply_a_record_extractor_top dnsx_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
